// ===== hdl/wlsp_pkg.sv =====
`timescale 1ns / 1ps
package wlsp_pkg;

   // request and response payloads
   typedef struct packed {
      logic        operation;
      logic [11:0] sample;
      logic [5:0]  view_row;
      logic [6:0]  view_column;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [6:0]  peak_column;
      logic [11:0] peak_value;
      logic [14:0] tone_hz;
      logic [1:0]  pixel_level;
      logic        pixel_lit;
   } rsp_type;

   // store port controls
   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      logic [1:0] wr_level;
   } store_ctl_type;

   // tone datapath stage loads
   typedef struct packed {
      logic ld_mul;
      logic ld_scale;
   } tone_ctl_type;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_PIXEL  = 1'b1;

   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_PIXEL   = 1'b1;

   localparam logic [1:0] CSR_TONE_ENABLE = 2'd0;
   localparam logic [1:0] CSR_NOISE_GATE  = 2'd1;
   localparam logic [1:0] CSR_TONE_MIN    = 2'd2;
   localparam logic [1:0] CSR_TONE_MAX    = 2'd3;

   localparam logic        TONE_ENABLE_RST = 1'b0;
   localparam logic [11:0] NOISE_GATE_RST  = 12'd409;
   localparam logic [14:0] TONE_MIN_RST    = 15'd200;
   localparam logic [14:0] TONE_MAX_RST    = 15'd4000;

   localparam logic [11:0] THRESH_1 = 12'd1023;
   localparam logic [11:0] THRESH_2 = 12'd2047;
   localparam logic [11:0] THRESH_3 = 12'd3071;

   localparam logic [1:0] LEVEL_0 = 2'd0;
   localparam logic [1:0] LEVEL_1 = 2'd1;
   localparam logic [1:0] LEVEL_2 = 2'd2;
   localparam logic [1:0] LEVEL_3 = 2'd3;

   // floor(x / 4095) == (x * RECIP) >> RECIP_SHIFT for any x below 2**27
   localparam logic [27:0] RECIP       = 28'd134250505;
   localparam int          RECIP_SHIFT = 39;
   localparam logic [16:0] TONE_LIMIT  = 17'd32767;

   function automatic logic [1:0] level_of(input logic [11:0] s);
      logic [1:0] lvl;
      if (s < THRESH_1)      lvl = LEVEL_0;
      else if (s < THRESH_2) lvl = LEVEL_1;
      else if (s < THRESH_3) lvl = LEVEL_2;
      else                   lvl = LEVEL_3;
      return lvl;
   endfunction

endpackage

// ===== hdl/wlsp_store.sv =====
`timescale 1ns / 1ps
module wlsp_store import wlsp_pkg::*; #(
   parameter int ADDR_W = 13,
   parameter int DEPTH  = 7040
) (
   input  logic                clock,
   input  logic                reset,
   input  store_ctl_type       ctl,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [1:0]          rd_level,
   output logic                busy
);

   logic [1:0]        mem [DEPTH];
   logic [1:0]        rd_level_ff;
   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              we;
   logic [ADDR_W-1:0] wa;
   logic [1:0]        wd;

   // clearing sweep after reset, one entry per cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign we = clr_busy_ff | ctl.wr_en;
   assign wa = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign wd = clr_busy_ff ? LEVEL_0 : ctl.wr_level;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (ctl.rd_en) begin
         rd_level_ff <= mem[rd_addr];
      end
   end

   assign rd_level = rd_level_ff;
   assign busy     = clr_busy_ff;

endmodule

// ===== hdl/wlsp_tone.sv =====
`timescale 1ns / 1ps
module wlsp_tone import wlsp_pkg::*; (
   input  logic         clock,
   input  tone_ctl_type ctl,
   input  logic [11:0]  peak,
   input  logic [14:0]  tone_min,
   input  logic [14:0]  tone_max,
   output logic [14:0]  tone_hz
);

   logic [14:0] span;
   logic [26:0] prod_ff, prod_in;
   logic [54:0] scaled_ff, scaled_in;
   logic [15:0] quot;
   logic [16:0] sum;

   assign span = (tone_max > tone_min) ? (tone_max - tone_min) : 15'd0;

   assign prod_in   = 27'(peak) * 27'(span);
   assign scaled_in = 55'(prod_ff) * 55'(RECIP);

   always_ff @(posedge clock) begin
      if (ctl.ld_mul) begin
         prod_ff <= prod_in;
      end
      if (ctl.ld_scale) begin
         scaled_ff <= scaled_in;
      end
   end

   assign quot    = scaled_ff[54:RECIP_SHIFT];
   assign sum     = 17'(tone_min) + 17'(quot);
   assign tone_hz = (sum > TONE_LIMIT) ? TONE_LIMIT[14:0] : sum[14:0];

endmodule

// ===== hdl/waterfall_level_store_peak_tone.sv =====
`timescale 1ns / 1ps
// Pipeline: an accepted request passes through s1, s2, s3 and the output register (out).
// Throughput: one request per cycle while req_ready is high (rsp_ready and the store clear can stall it);
// the level store takes one write and one read a cycle. Reset: synchronous, active high; counters, peak
// tracker and registers return to defaults, then a sweep zeroes all (ROWS+1) * 2**ceil(log2(COLUMNS))
// store entries (7040 by default), during which req_ready stays low.
module waterfall_level_store_peak_tone import wlsp_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int ROWS    = 54
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wr_data
);

   localparam int SLOTS  = ROWS + 1;          // ring of rows plus the live row
   localparam int CW     = $clog2(COLUMNS);
   localparam int SW     = $clog2(SLOTS);
   localparam int ADDR_W = SW + CW;
   localparam int DEPTH  = SLOTS * (1 << CW); // {slot, column} addressing

   // ---------------- configuration registers ----------------
   logic        tone_en_ff;
   logic [11:0] gate_ff;
   logic [14:0] tmin_ff, tmax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_en_ff <= TONE_ENABLE_RST;
         gate_ff    <= NOISE_GATE_RST;
         tmin_ff    <= TONE_MIN_RST;
         tmax_ff    <= TONE_MAX_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TONE_ENABLE: tone_en_ff <= csr_wr_data[0];
            CSR_NOISE_GATE:  gate_ff    <= csr_wr_data[11:0];
            CSR_TONE_MIN:    tmin_ff    <= csr_wr_data;
            CSR_TONE_MAX:    tmax_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   // each stage moves when the one after it is empty or moving
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, vo_ff, vo_in;
   logic open_o, open3, open2, open1;
   logic ld2, ld3, ldo;
   logic req_fire, clr_busy;

   assign open_o = ~vo_ff | rsp_ready;
   assign open3  = ~v3_ff | open_o;
   assign open2  = ~v2_ff | open3;
   assign open1  = ~v1_ff | open2;

   assign req_ready = open1 & ~clr_busy;
   assign req_fire  = req_valid & req_ready;

   assign ld2 = open2 & v1_ff;
   assign ld3 = open3 & v2_ff;
   assign ldo = open_o & v3_ff;

   // ---------------- live row, ring pointer, peak tracker ----------------
   logic [CW-1:0] col_ff, col_in;
   logic [SW-1:0] newest_ff, newest_in, live;
   logic [11:0]   pk_val_ff, pk_val_in, base_val;
   logic [CW-1:0] pk_col_ff, pk_col_in, base_col;
   logic          is_sample, col_last, take;

   assign is_sample = req_data.operation == OP_SAMPLE;
   assign col_last  = col_ff == CW'(COLUMNS - 1);
   assign live      = (newest_ff == SW'(SLOTS - 1)) ? '0 : newest_ff + 1'b1;

   // a fresh row restarts the tracker; strict compare keeps the first column
   assign base_val = (col_ff == '0) ? '0 : pk_val_ff;
   assign base_col = (col_ff == '0) ? '0 : pk_col_ff;
   assign take     = req_data.sample > base_val;

   always_comb begin
      col_in    = col_ff;
      newest_in = newest_ff;
      pk_val_in = pk_val_ff;
      pk_col_in = pk_col_ff;
      if (req_fire && is_sample) begin
         pk_val_in = take ? req_data.sample : base_val;
         pk_col_in = take ? col_ff : base_col;
         if (col_last) begin
            col_in    = '0;
            newest_in = live;   // live row joins the ring as newest
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         newest_ff <= '0;
         pk_val_ff <= '0;
         pk_col_ff <= '0;
      end else begin
         col_ff    <= col_in;
         newest_ff <= newest_in;
         pk_val_ff <= pk_val_in;
         pk_col_ff <= pk_col_in;
      end
   end

   // ---------------- store addressing ----------------
   logic [31:0]       vr32, vc32, nw32, slot32, pkc32;
   logic              in_range;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   store_ctl_type     st_ctl;
   logic [1:0]        rd_level;

   assign vr32   = 32'(req_data.view_row);
   assign vc32   = 32'(req_data.view_column);
   assign nw32   = 32'(newest_ff);
   // display row 0 is the newest committed slot, older rows step back round the ring
   assign slot32 = (nw32 >= vr32) ? (nw32 - vr32) : (nw32 + 32'(SLOTS) - vr32);
   assign in_range = (vr32 < 32'(ROWS)) && (vc32 < 32'(COLUMNS));

   assign wr_addr = {live, col_ff};
   assign rd_addr = {slot32[SW-1:0], vc32[CW-1:0]};

   assign st_ctl.wr_en    = req_fire & is_sample;
   assign st_ctl.rd_en    = req_fire & ~is_sample;
   assign st_ctl.wr_level = level_of(req_data.sample);

   wlsp_store #(
      .ADDR_W (ADDR_W),
      .DEPTH  (DEPTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (st_ctl),
      .wr_addr  (wr_addr),
      .rd_addr  (rd_addr),
      .rd_level (rd_level),
      .busy     (clr_busy)
   );

   // ---------------- s1: request registered, store read in flight ----------------
   logic        kind1_ff, inr1_ff;
   logic [6:0]  pkcol1_ff;
   logic [11:0] pkval1_ff;
   logic [1:0]  dith1_ff, dith1_in;

   assign pkc32    = 32'(pk_col_in);
   assign dith1_in = req_data.view_row[1:0] + req_data.view_column[1:0];
   // only pixel reads and row-completing samples produce a response
   assign v1_in    = open1 ? (req_fire & (~is_sample | col_last)) : v1_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind1_ff  <= is_sample ? KIND_SUMMARY : KIND_PIXEL;
         pkcol1_ff <= pkc32[6:0];
         pkval1_ff <= pk_val_in;
         inr1_ff   <= in_range;
         dith1_ff  <= dith1_in;
      end
   end

   // ---------------- s2: pixel decode, peak * span ----------------
   logic        kind2_ff, silent2_ff, silent2_in, lit2_ff, lit2_in;
   logic [6:0]  pkcol2_ff;
   logic [11:0] pkval2_ff;
   logic [1:0]  lvl2_ff, lvl2_in;

   assign lvl2_in    = inr1_ff ? rd_level : LEVEL_0;
   assign silent2_in = ~tone_en_ff | (pkval1_ff <= gate_ff);

   // ordered dither: level 1 on a quarter of pixels, level 2 on half
   always_comb begin
      case (lvl2_in)
         LEVEL_1: lit2_in = dith1_ff == 2'd0;
         LEVEL_2: lit2_in = ~dith1_ff[0];
         LEVEL_3: lit2_in = 1'b1;
         default: lit2_in = 1'b0;
      endcase
   end

   assign v2_in = open2 ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (ld2) begin
         kind2_ff   <= kind1_ff;
         pkcol2_ff  <= pkcol1_ff;
         pkval2_ff  <= pkval1_ff;
         silent2_ff <= silent2_in;
         lvl2_ff    <= lvl2_in;
         lit2_ff    <= lit2_in;
      end
   end

   // ---------------- s3: reciprocal scale ----------------
   logic        kind3_ff, silent3_ff, lit3_ff;
   logic [6:0]  pkcol3_ff;
   logic [11:0] pkval3_ff;
   logic [1:0]  lvl3_ff;

   assign v3_in = open3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (ld3) begin
         kind3_ff   <= kind2_ff;
         pkcol3_ff  <= pkcol2_ff;
         pkval3_ff  <= pkval2_ff;
         silent3_ff <= silent2_ff;
         lvl3_ff    <= lvl2_ff;
         lit3_ff    <= lit2_ff;
      end
   end

   tone_ctl_type tn_ctl;
   logic [14:0]  tone_val;

   assign tn_ctl.ld_mul   = ld2;
   assign tn_ctl.ld_scale = ld3;

   wlsp_tone u_tone (
      .clock    (clock),
      .ctl      (tn_ctl),
      .peak     (pkval1_ff),
      .tone_min (tmin_ff),
      .tone_max (tmax_ff),
      .tone_hz  (tone_val)
   );

   // ---------------- output register ----------------
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in = '0;
      rsp_in.result_kind = kind3_ff;
      if (kind3_ff == KIND_PIXEL) begin
         rsp_in.pixel_level = lvl3_ff;
         rsp_in.pixel_lit   = lit3_ff;
      end else begin
         rsp_in.peak_column = pkcol3_ff;
         rsp_in.peak_value  = pkval3_ff;
         rsp_in.tone_hz     = silent3_ff ? 15'd0 : tone_val;
      end
   end

   assign vo_in = open_o ? v3_ff : vo_ff;

   always_ff @(posedge clock) begin
      if (ldo) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_ready)
      else $error("request accepted during store clear");

   a_row_wraps: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_sample && col_last |=> col_ff == '0 && newest_ff == $past(live))
      else $error("row commit did not advance ring");

   a_lit_needs_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pixel_lit |-> rsp_data.pixel_level != LEVEL_0)
      else $error("lit pixel with level zero");

   a_summary_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_SUMMARY |->
         rsp_data.pixel_level == LEVEL_0 && !rsp_data.pixel_lit)
      else $error("summary carries pixel data");

   a_tone_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_SUMMARY && !tone_en_ff |->
         rsp_data.tone_hz == 15'd0)
      else $error("tone given while disabled");
`endif

endmodule
